// ===== rtl/sph_pkg.sv =====
`timescale 1ns / 1ps
package sph_pkg;

	localparam int CW   = 32;
	localparam int EW   = CW + 1;
	localparam int PPW  = 2 * EW;
	localparam int PW   = PPW + 1;
	localparam int LOW  = EW;
	localparam int HIW  = PW - LOW;
	localparam int XPW  = EW + HIW;
	localparam int TW   = 100;
	localparam int MW   = 120;
	localparam int LAT  = 9;
	localparam int NAX  = 3;
	localparam int NDOT = 4;
	localparam int CFG_IW = 3;

	localparam int TOL_DEN   = 100000;
	localparam int TOL_HI    = 100001;
	localparam int TDIST_DEN = 10000;
	localparam int TDIST_HI  = 9999;

	localparam logic signed [MW-1:0] K_DEN = MW'(TOL_DEN);
	localparam logic signed [MW-1:0] K_HI  = MW'(TOL_HI);
	localparam logic signed [MW-1:0] K_TD  = MW'(TDIST_DEN);
	localparam logic signed [MW-1:0] K_TDH = MW'(TDIST_HI);

	typedef enum logic [CFG_IW-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DELTA_X  = 3'd3,
		REG_DELTA_Y  = 3'd4,
		REG_DELTA_Z  = 3'd5
	} cfg_reg_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [NAX-1:0][CW-1:0] org;
		logic [NAX-1:0][CW-1:0] dlt;
	} seg_t;

	function automatic logic signed [EW-1:0] sx(input logic [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

endpackage

// ===== rtl/sph_box.sv =====
`timescale 1ns / 1ps
module sph_box (
	input  logic                                  clk,
	input  sph_pkg::seg_t                         seg,
	input  logic [sph_pkg::NAX-1:0][sph_pkg::CW-1:0] lo,
	input  logic [sph_pkg::NAX-1:0][sph_pkg::CW-1:0] hi,
	output logic                                  hit
);
	import sph_pkg::*;

	logic signed [EW-1:0]  nl_s1 [NAX];
	logic signed [EW-1:0]  nh_s1 [NAX];
	logic [CW-1:0]         ad_s1 [NAX];
	logic [NAX-1:0]        ng_s1, zr_s1, ok_s1;

	logic signed [EW-1:0]  en_s2 [NAX];
	logic signed [EW-1:0]  ex_s2 [NAX];
	logic [CW-1:0]         ad_s2 [NAX];
	logic [NAX-1:0]        zr_s2, ok_s2;

	logic [NAX-1:0]        zr_s3, fl_s3;
	logic [NAX*NAX-1:0]    pair_ok;

	logic                  hit_s4;
	logic [LAT-5:0]        dly_q;

	genvar k, i, j;
	generate
		for (k = 0; k < NAX; k++) begin : g_ax
			logic signed [EW-1:0] f1, f2;
			always_comb begin
				f1 = ng_s1[k] ? -nl_s1[k] : nl_s1[k];
				f2 = ng_s1[k] ? -nh_s1[k] : nh_s1[k];
			end
			always_ff @(posedge clk) begin
				nl_s1[k] <= sx(lo[k]) - sx(seg.org[k]);
				nh_s1[k] <= sx(hi[k]) - sx(seg.org[k]);
				ng_s1[k] <= seg.dlt[k][CW-1];
				ad_s1[k] <= seg.dlt[k][CW-1] ? (~seg.dlt[k] + 1'b1) : seg.dlt[k];
				zr_s1[k] <= (seg.dlt[k] == '0);
				ok_s1[k] <= ($signed(seg.org[k]) >= $signed(lo[k])) &&
				            ($signed(seg.org[k]) <= $signed(hi[k]));
				en_s2[k] <= (f1 > f2) ? f2 : f1;
				ex_s2[k] <= (f1 > f2) ? f1 : f2;
				ad_s2[k] <= ad_s1[k];
				zr_s2[k] <= zr_s1[k];
				ok_s2[k] <= ok_s1[k];
				zr_s3[k] <= zr_s2[k];
				fl_s3[k] <= zr_s2[k] ? ok_s2[k] :
				            ((ex_s2[k] >= 0) && (en_s2[k] <= $signed({1'b0, ad_s2[k]})));
			end
		end
		for (i = 0; i < NAX; i++) begin : g_i
			for (j = 0; j < NAX; j++) begin : g_j
				if (i == j) begin : g_same
					assign pair_ok[i*NAX+j] = 1'b1;
				end else begin : g_pair
					logic signed [PPW-1:0] pe_s3, px_s3;
					always_ff @(posedge clk) begin
						pe_s3 <= en_s2[i] * $signed({1'b0, ad_s2[j]});
						px_s3 <= ex_s2[j] * $signed({1'b0, ad_s2[i]});
					end
					assign pair_ok[i*NAX+j] = zr_s3[i] | zr_s3[j] | (pe_s3 <= px_s3);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		hit_s4 <= (&fl_s3) & (&pair_ok);
		dly_q  <= {dly_q[LAT-6:0], hit_s4};
	end

	assign hit = dly_q[LAT-5];

endmodule

// ===== rtl/sph_tri.sv =====
`timescale 1ns / 1ps
module sph_tri (
	input  logic                                     clk,
	input  sph_pkg::seg_t                            seg,
	input  logic [sph_pkg::NAX-1:0][sph_pkg::CW-1:0] va,
	input  logic [sph_pkg::NAX-1:0][sph_pkg::CW-1:0] vb,
	input  logic [sph_pkg::NAX-1:0][sph_pkg::CW-1:0] vc,
	output logic                                     hit
);
	import sph_pkg::*;

	logic signed [EW-1:0]  e1_s1 [NAX], e2_s1 [NAX], s_s1 [NAX];
	logic signed [EW-1:0]  e1_s2 [NAX], e2_s2 [NAX], s_s2 [NAX];
	logic signed [EW-1:0]  e1_s3 [NAX], e2_s3 [NAX], s_s3 [NAX];
	logic signed [PPW-1:0] pa_s2 [NAX], pb_s2 [NAX], qa_s2 [NAX], qb_s2 [NAX];
	logic signed [PW-1:0]  p_s3 [NAX], q_s3 [NAX];
	logic signed [EW-1:0]  xop [NDOT][NAX];
	logic signed [PW-1:0]  yop [NDOT][NAX];
	logic signed [XPW-1:0] pl_s4 [NDOT][NAX], ph_s4 [NDOT][NAX];
	logic signed [TW-1:0]  tm_s5 [NDOT][NAX];
	logic signed [TW-1:0]  sm_s6 [NDOT];
	logic signed [TW-1:0]  nm_s7 [NDOT];
	logic                  nz_s7, nz_s8;
	logic signed [MW-1:0]  ku_s8, kv_s8, kuv_s8, dh_s8, kt_s8, dk_s8, dt_s8;
	logic                  hit_s9;

	genvar k, m;
	generate
		for (k = 0; k < NAX; k++) begin : g_ax
			localparam int K1 = (k + 1) % NAX;
			localparam int K2 = (k + 2) % NAX;
			always_ff @(posedge clk) begin
				e1_s1[k] <= sx(vb[k]) - sx(va[k]);
				e2_s1[k] <= sx(vc[k]) - sx(va[k]);
				s_s1[k]  <= sx(seg.org[k]) - sx(va[k]);
				pa_s2[k] <= sx(seg.dlt[K1]) * e2_s1[K2];
				pb_s2[k] <= sx(seg.dlt[K2]) * e2_s1[K1];
				qa_s2[k] <= s_s1[K1] * e1_s1[K2];
				qb_s2[k] <= s_s1[K2] * e1_s1[K1];
				e1_s2[k] <= e1_s1[k];
				e2_s2[k] <= e2_s1[k];
				s_s2[k]  <= s_s1[k];
				p_s3[k]  <= PW'(pa_s2[k]) - PW'(pb_s2[k]);
				q_s3[k]  <= PW'(qa_s2[k]) - PW'(qb_s2[k]);
				e1_s3[k] <= e1_s2[k];
				e2_s3[k] <= e2_s2[k];
				s_s3[k]  <= s_s2[k];
			end
			assign xop[0][k] = e1_s3[k];
			assign xop[1][k] = s_s3[k];
			assign xop[2][k] = sx(seg.dlt[k]);
			assign xop[3][k] = e2_s3[k];
			assign yop[0][k] = p_s3[k];
			assign yop[1][k] = p_s3[k];
			assign yop[2][k] = q_s3[k];
			assign yop[3][k] = q_s3[k];
			for (m = 0; m < NDOT; m++) begin : g_dot
				always_ff @(posedge clk) begin
					pl_s4[m][k] <= xop[m][k] * $signed({1'b0, yop[m][k][LOW-1:0]});
					ph_s4[m][k] <= xop[m][k] * $signed(yop[m][k][PW-1:LOW]);
					tm_s5[m][k] <= $signed({ph_s4[m][k][TW-LOW-1:0], {LOW{1'b0}}})
					               + TW'(pl_s4[m][k]);
				end
			end
		end
		for (m = 0; m < NDOT; m++) begin : g_sum
			always_ff @(posedge clk) begin
				sm_s6[m] <= tm_s5[m][0] + tm_s5[m][1] + tm_s5[m][2];
				nm_s7[m] <= sm_s6[0][TW-1] ? -sm_s6[m] : sm_s6[m];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		nz_s7  <= (sm_s6[0] != '0);
		nz_s8  <= nz_s7;
		ku_s8  <= MW'(nm_s7[1]) * K_DEN;
		kv_s8  <= MW'(nm_s7[2]) * K_DEN;
		kuv_s8 <= (MW'(nm_s7[1]) + MW'(nm_s7[2])) * K_DEN;
		dh_s8  <= MW'(nm_s7[0]) * K_HI;
		kt_s8  <= MW'(nm_s7[3]) * K_TD;
		dk_s8  <= MW'(nm_s7[0]) * K_TDH;
		dt_s8  <= MW'(nm_s7[0]);
		hit_s9 <= nz_s8 && (ku_s8 >= -dt_s8) && (ku_s8 <= dh_s8) &&
		          (kv_s8 >= -dt_s8) && (kuv_s8 <= dh_s8) &&
		          (kt_s8 > dt_s8) && (dk_s8 > kt_s8);
	end

	assign hit = hit_s9;

endmodule

// ===== rtl/segment_primitive_hit_test.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; busy never rises, the 9-stage pipeline
// always advances and the receiver cannot stall it.
// Reset: arst_n clears the segment registers to zero and drops all in-flight
// transactions; no clearing pass.
module segment_primitive_hit_test (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  sph_pkg::coord_t             a_x,
	input  sph_pkg::coord_t             a_y,
	input  sph_pkg::coord_t             a_z,
	input  sph_pkg::coord_t             b_x,
	input  sph_pkg::coord_t             b_y,
	input  sph_pkg::coord_t             b_z,
	input  sph_pkg::coord_t             c_x,
	input  sph_pkg::coord_t             c_y,
	input  sph_pkg::coord_t             c_z,
	output logic                        done,
	output logic                        hit,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sph_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [sph_pkg::CW-1:0]      cfg_data
);
	import sph_pkg::*;

	seg_t                        seg_q;
	logic [LAT-1:0]              vld_q;
	logic [LAT-1:0]              typ_q;
	logic                        box_hit, tri_hit;
	logic [NAX-1:0][CW-1:0]      va, vb, vc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign va = {a_z, a_y, a_x};
	assign vb = {b_z, b_y, b_x};
	assign vc = {c_z, c_y, c_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: seg_q.org[0] <= cfg_data;
				REG_ORIGIN_Y: seg_q.org[1] <= cfg_data;
				REG_ORIGIN_Z: seg_q.org[2] <= cfg_data;
				REG_DELTA_X:  seg_q.dlt[0] <= cfg_data;
				REG_DELTA_Y:  seg_q.dlt[1] <= cfg_data;
				REG_DELTA_Z:  seg_q.dlt[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		typ_q <= {typ_q[LAT-2:0], req_type};
	end

	sph_box u_box (
		.clk (clk),
		.seg (seg_q),
		.lo  (va),
		.hi  (vb),
		.hit (box_hit)
	);

	sph_tri u_tri (
		.clk (clk),
		.seg (seg_q),
		.va  (va),
		.vb  (vb),
		.vc  (vc),
		.hit (tri_hit)
	);

	assign done = vld_q[LAT-1];
	assign hit  = typ_q[LAT-1] ? tri_hit : box_hit;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted transaction");

	a_degenerate_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type && a_x == b_x && a_y == b_y && a_z == b_z)
		|-> ##LAT !hit)
		else $error("degenerate triangle reported a hit");

endmodule
